// ===== design/ace_pkg.sv =====
// Shared types and constants for the accumulator CPU execute core.
// Holds opcode values, the decoded instruction kind and the queue entry format.
// No dependencies.
package ace_pkg;

  // Raw opcode values on the instruction channel
  localparam logic [3:0] OPC_LOAD  = 4'd1;
  localparam logic [3:0] OPC_ADD   = 4'd2;
  localparam logic [3:0] OPC_STORE = 4'd3;
  localparam logic [3:0] OPC_SUB   = 4'd4;
  localparam logic [3:0] OPC_IN    = 4'd5;
  localparam logic [3:0] OPC_OUT   = 4'd6;
  localparam logic [3:0] OPC_END   = 4'd7;
  localparam logic [3:0] OPC_JMP   = 4'd8;
  localparam logic [3:0] OPC_SKIPZ = 4'd9;

  // PC increments
  localparam logic [7:0] PC_STEP      = 8'd2;
  localparam logic [7:0] PC_SKIP_STEP = 8'd4;

  // Instruction class after decode; faults are classes of their own
  typedef enum logic [3:0] {
    K_BADCMD,
    K_BADADDR,
    K_LOAD,
    K_ADD,
    K_STORE,
    K_SUB,
    K_IN,
    K_OUT,
    K_END,
    K_JMP,
    K_SKIPZ
  } kind_t;

  // One decoded instruction as it sits in the queue
  typedef struct packed {
    kind_t      kind;
    logic [7:0] operand;
  } uop_t;

endpackage

// ===== design/ace_front.sv =====
// Front end of the execute core: takes instruction beats and classifies them.
// Flags unknown opcodes and out-of-range data addresses. Depends on ace_pkg.
module ace_front #(
  parameter int DATA_WORDS = 16
) (
  input  logic          in_valid,
  input  logic [3:0]    in_command,
  input  logic [7:0]    in_operand,
  input  logic          q_full,
  output logic          push_o,
  output ace_pkg::uop_t uop_o
);
  import ace_pkg::*;

  localparam logic [8:0] WORDS_C = 9'(DATA_WORDS);

  logic  addr_ok;
  logic  mem_op;
  kind_t kind;

  assign addr_ok = ({1'b0, in_operand} < WORDS_C);

  // Opcode decode, then fold address faults into the class
  always_comb begin
    mem_op = 1'b0;
    kind   = K_BADCMD;
    case (in_command)
      OPC_LOAD: begin
        kind   = K_LOAD;
        mem_op = 1'b1;
      end
      OPC_ADD: begin
        kind   = K_ADD;
        mem_op = 1'b1;
      end
      OPC_STORE: begin
        kind   = K_STORE;
        mem_op = 1'b1;
      end
      OPC_SUB: begin
        kind   = K_SUB;
        mem_op = 1'b1;
      end
      OPC_IN:    kind = K_IN;
      OPC_OUT:   kind = K_OUT;
      OPC_END:   kind = K_END;
      OPC_JMP:   kind = K_JMP;
      OPC_SKIPZ: kind = K_SKIPZ;
      default:   kind = K_BADCMD;
    endcase
    if (mem_op && !addr_ok) begin
      kind = K_BADADDR;
    end
  end

  assign push_o        = in_valid && !q_full;
  assign uop_o.kind    = kind;
  assign uop_o.operand = in_operand;

endmodule

// ===== design/ace_queue.sv =====
// Two-entry queue between the decode front end and the execute back end.
// Full flag comes from the registered count only. Depends on ace_pkg.
module ace_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_i,
  input  ace_pkg::uop_t push_data_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output ace_pkg::uop_t head_o
);
  import ace_pkg::*;

  localparam logic [1:0] DEPTH_C = 2'd2;

  uop_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Pointer and count update
  always_comb begin
    wr_ptr_nxt = push_i ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_i ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign full_o       = (cnt_r == DEPTH_C);
  assign head_valid_o = (cnt_r != 2'd0);
  assign head_o       = ent_r[rd_ptr_r];

endmodule

// ===== design/ace_back.sv =====
// Back end of the execute core: data memory, accumulator, PC, halt flag and
// the result register. Reads memory when an entry leaves the queue for the
// execute slot and executes it from there. Depends on ace_pkg.
module ace_back #(
  parameter int DATA_WORDS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid_i,
  input  ace_pkg::uop_t      q_head_i,
  output logic               pop_o,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_next_pc,
  output logic signed [31:0] out_accumulator,
  output logic               out_out_valid,
  output logic               out_halted,
  output logic               out_bad_command,
  output logic               out_bad_address
);
  import ace_pkg::*;

  localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;

  // Data memory and per-word written flags
  logic [DATA_WIDTH-1:0] mem [DATA_WORDS];
  logic [DATA_WORDS-1:0] vld_r;
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  hit_r;
  logic                  fwd_r;

  // Execute slot
  logic            ex_v_r, ex_v_nxt;
  uop_t            ex_uop_r;
  logic            ex_go;

  // Architectural state
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [7:0]            pc_r, pc_nxt;
  logic                  halt_r, halt_nxt;

  // Result register
  logic        ob_v_r, ob_v_nxt;
  logic [7:0]  ob_pc_r;
  logic [31:0] ob_acc_r;
  logic        ob_outv_r;
  logic        ob_halt_r;
  logic        ob_badc_r;
  logic        ob_bada_r;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         ex_addr;
  logic                  rd_en;
  logic                  is_store;
  logic                  mem_we;
  logic                  outv, badc, bada;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [63:0]           acc_wide;

  // Handshake between queue, execute slot and result register
  assign ex_go = ex_v_r && (!ob_v_r || !out_stall);
  assign pop_o = q_valid_i && (!ex_v_r || ex_go);
  assign ex_v_nxt = pop_o ? 1'b1 : (ex_go ? 1'b0 : ex_v_r);
  assign ob_v_nxt = ex_go || (ob_v_r && out_stall);

  assign rd_addr = q_head_i.operand[AW-1:0];
  assign ex_addr = ex_uop_r.operand[AW-1:0];
  assign rd_en   = pop_o && (q_head_i.kind == K_LOAD || q_head_i.kind == K_ADD ||
                             q_head_i.kind == K_SUB);

  // Operand: a store executing on the same edge as the read wins; a store leaves
  // the accumulator as it was, so acc_r is still the stored value at execute
  assign rd_data = fwd_r ? acc_r : (hit_r ? mem_q_r : '0);

  // Execute
  always_comb begin
    acc_nxt  = acc_r;
    pc_nxt   = 8'(pc_r + PC_STEP);
    halt_nxt = halt_r;
    is_store = 1'b0;
    outv     = 1'b0;
    badc     = 1'b0;
    bada     = 1'b0;
    if (halt_r) begin
      pc_nxt = pc_r;
    end else begin
      case (ex_uop_r.kind)
        K_LOAD:    acc_nxt = rd_data;
        K_ADD:     acc_nxt = acc_r + rd_data;
        K_SUB:     acc_nxt = acc_r - rd_data;
        K_STORE:   is_store = 1'b1;
        K_IN:      acc_nxt = DATA_WIDTH'(ex_uop_r.operand);
        K_OUT:     outv = 1'b1;
        K_END: begin
          halt_nxt = 1'b1;
          pc_nxt   = pc_r;
        end
        K_JMP:     pc_nxt = ex_uop_r.operand;
        K_SKIPZ: begin
          if (acc_r == '0) begin
            pc_nxt = 8'(pc_r + PC_SKIP_STEP);
          end
        end
        K_BADADDR: bada = 1'b1;
        K_BADCMD:  badc = 1'b1;
        default:   badc = 1'b1;
      endcase
    end
  end

  assign mem_we   = ex_go && is_store;
  assign acc_wide = 64'(acc_nxt);

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_v_r <= 1'b0;
      ob_v_r <= 1'b0;
      acc_r  <= '0;
      pc_r   <= '0;
      halt_r <= 1'b0;
      vld_r  <= '0;
    end else begin
      ex_v_r <= ex_v_nxt;
      ob_v_r <= ob_v_nxt;
      if (ex_go) begin
        acc_r  <= acc_nxt;
        pc_r   <= pc_nxt;
        halt_r <= halt_nxt;
      end
      if (mem_we) begin
        vld_r[ex_addr] <= 1'b1;
      end
    end
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ex_addr] <= acc_r;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  // Execute slot payload and read qualifiers
  always_ff @(posedge clk) begin
    if (pop_o) begin
      ex_uop_r <= q_head_i;
      hit_r    <= rd_en && vld_r[rd_addr];
      fwd_r    <= rd_en && mem_we && (ex_addr == rd_addr);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (ex_go) begin
      ob_pc_r   <= pc_nxt;
      ob_acc_r  <= acc_wide[31:0];
      ob_outv_r <= outv;
      ob_halt_r <= halt_nxt;
      ob_badc_r <= badc;
      ob_bada_r <= bada;
    end
  end

  assign out_valid       = ob_v_r;
  assign out_next_pc     = ob_pc_r;
  assign out_accumulator = ob_acc_r;
  assign out_out_valid   = ob_outv_r;
  assign out_halted      = ob_halt_r;
  assign out_bad_command = ob_badc_r;
  assign out_bad_address = ob_bada_r;

  // Halt is sticky and freezes PC and accumulator
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag dropped");

  a_halt_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> ($stable(pc_r) && $stable(acc_r)))
    else $error("state changed while halted");

  // Halted machine never writes memory
  a_halt_no_store: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !mem_we) else $error("store while halted");

  // An executed instruction always lands in the result register
  a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    ex_go |=> ob_v_r) else $error("executed beat lost");

  // At most one status flag per result
  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    ob_v_r |-> ($countones({ob_outv_r, ob_badc_r, ob_bada_r}) <= 1))
    else $error("conflicting status flags");

endmodule

// ===== design/accumulator_cpu_execute_core.sv =====
// Top level of the accumulator CPU execute core.
// Instantiates ace_front, ace_queue and ace_back. Depends on ace_pkg.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    command[3:0], operand[7:0]
//   out_     output     out_valid / out_stall  next_pc, accumulator, flags
//
// Throughput is one instruction per cycle while out_stall is low. The data
// memory read is registered as an entry leaves the queue for the execute slot.
// A beat passes through the queue, the execute slot and the result register.
// Reset clears accumulator, PC, halt flag and the per-word written flags at
// once; no clearing pass is run, unwritten words read as zero.
// out_stall holds the result register; the queue absorbs two beats before
// in_stall rises.
module accumulator_cpu_execute_core #(
  parameter int DATA_WORDS = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         in_command,
  input  logic [7:0]         in_operand,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_next_pc,
  output logic signed [31:0] out_accumulator,
  output logic               out_out_valid,
  output logic               out_halted,
  output logic               out_bad_command,
  output logic               out_bad_address
);
  import ace_pkg::*;

  logic q_full;
  logic push;
  logic pop;
  logic q_valid;
  uop_t push_uop;
  uop_t head_uop;

  assign in_stall = q_full;

  // Decode
  ace_front #(
    .DATA_WORDS(DATA_WORDS)
  ) u_front (
    .in_valid  (in_valid),
    .in_command(in_command),
    .in_operand(in_operand),
    .q_full    (q_full),
    .push_o    (push),
    .uop_o     (push_uop)
  );

  // Decoupling queue
  ace_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_uop),
    .pop_i       (pop),
    .full_o      (q_full),
    .head_valid_o(q_valid),
    .head_o      (head_uop)
  );

  // Execute
  ace_back #(
    .DATA_WORDS(DATA_WORDS),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid_i      (q_valid),
    .q_head_i       (head_uop),
    .pop_o          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_next_pc    (out_next_pc),
    .out_accumulator(out_accumulator),
    .out_out_valid  (out_out_valid),
    .out_halted     (out_halted),
    .out_bad_command(out_bad_command),
    .out_bad_address(out_bad_address)
  );

endmodule
